// ===== hw/rtl/tbt_pkg.sv =====
// shared types and codes for the tracked blob table
// no dependencies
`default_nettype none
package tbt_pkg;
    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_FRAME  = 2'd2,
        KIND_DROP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MAX_X = 3'd1,
        REG_MIN_Y = 3'd2,
        REG_MAX_Y = 3'd3,
        REG_POS_S = 3'd4,
        REG_VEL_S = 3'd5
    } t_reg;

    typedef struct packed {
        logic [31:0] label;
        logic [14:0] cx;
        logic [14:0] cy;
        logic [20:0] vx;
        logic [20:0] vy;
        logic [10:0] bx;
        logic [10:0] by;
        logic [10:0] bw;
        logic [10:0] bh;
    } t_entry;

    // shared squarer operation select
    typedef enum logic [1:0] {
        SQ_CX = 2'd0,
        SQ_CY = 2'd1,
        SQ_VX = 2'd2,
        SQ_VY = 2'd3
    } t_sq_sel;
endpackage
`default_nettype wire

// ===== hw/rtl/tbt_sqacc.sv =====
// shared difference squarer with accumulator
// no package dependencies
`default_nettype none
module tbt_sqacc (
    input  wire logic        i_clk,
    input  wire logic        i_clear,
    input  wire logic        i_en,
    input  wire logic [20:0] i_a,
    input  wire logic [20:0] i_b,
    output logic      [43:0] o_acc
);
    logic signed [21:0] diff;
    logic        [21:0] mag;
    logic        [43:0] sq;
    logic        [43:0] r_acc;
    logic        [43:0] n_acc;

    always_comb begin
        diff = $signed({i_a[20], i_a}) - $signed({i_b[20], i_b});
        mag = diff[21] ? 22'(-diff) : 22'(diff);
        sq = 44'(mag) * 44'(mag);
        n_acc = r_acc;
        if (i_clear) begin
            // clear with enable starts a new sum
            n_acc = i_en ? sq : '0;
        end else if (i_en) begin
            n_acc = r_acc + sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== hw/rtl/tracked_blob_table_unit.sv =====
// tracked blob table: label-keyed table of up to TABLE_ENTRIES blobs, walked one
// slot at a time over a one-write, one-read entry memory with registered read.
// a request is taken when start is high and busy is low. a detection inside the
// window holds busy while it walks the slots (a label match adds four squarer
// passes and a decision state after the slot compare); a detection outside the
// window is taken without going busy. an end of frame holds busy for a delete
// walk and an update walk over the slots, then the frame marker. results are
// one-cycle strobes on o_valid, deletes and updates at most one per slot visited,
// with the frame marker right after the last update; the receiver cannot stall
// them. registers are written only while busy is low.
// depends on tbt_pkg and tbt_sqacc
`default_nettype none
module tracked_blob_table_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_blob_label,
    input  wire logic [14:0] i_center_x,
    input  wire logic [14:0] i_center_y,
    input  wire logic signed [20:0] i_velocity_x,
    input  wire logic signed [20:0] i_velocity_y,
    input  wire logic [10:0] i_box_x,
    input  wire logic [10:0] i_box_y,
    input  wire logic [10:0] i_box_width,
    input  wire logic [10:0] i_box_height,
    output logic             o_valid,
    output logic [1:0]       o_report_kind,
    output logic [31:0]      o_report_label,
    output logic [14:0]      o_report_center_x,
    output logic [14:0]      o_report_center_y,
    output logic signed [20:0] o_report_velocity_x,
    output logic signed [20:0] o_report_velocity_y,
    output logic [10:0]      o_report_box_x,
    output logic [10:0]      o_report_box_y,
    output logic [10:0]      o_report_box_width,
    output logic [10:0]      o_report_box_height,
    output logic             o_last_of_run
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHK, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_DEC,
        S_DEL, S_DEL_OUT, S_UPD, S_UPD_OUT, S_FRAME
    } t_state;

    t_state r_state;
    tbt_pkg::t_entry mem [TABLE_ENTRIES];
    tbt_pkg::t_entry r_rd;
    tbt_pkg::t_entry r_in;
    logic [TABLE_ENTRIES-1:0] r_vld, r_fnd, r_upd;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_slot;
    logic [CW-1:0] r_free;
    logic r_has_free;
    logic [14:0] r_minx, r_maxx, r_miny, r_maxy;
    logic [10:0] r_pos_s;
    logic [12:0] r_vel_s;
    logic [43:0] r_dp;
    logic r_wr;
    logic [IW-1:0] r_wa;

    logic        sq_clear, sq_en;
    logic [20:0] sq_a, sq_b;
    logic [43:0] sq_acc;
    tbt_pkg::t_sq_sel sq_sel;
    logic [IW-1:0] idx;

    assign idx = r_idx[IW-1:0];
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    always_comb begin
        sq_sel = tbt_pkg::SQ_CX;
        unique case (r_state)
            S_SQ1: sq_sel = tbt_pkg::SQ_CY;
            S_SQ2: sq_sel = tbt_pkg::SQ_VX;
            S_SQ3: sq_sel = tbt_pkg::SQ_VY;
            default: sq_sel = tbt_pkg::SQ_CX;
        endcase
        unique case (sq_sel)
            tbt_pkg::SQ_CX: begin sq_a = {6'd0, r_in.cx}; sq_b = {6'd0, r_rd.cx}; end
            tbt_pkg::SQ_CY: begin sq_a = {6'd0, r_in.cy}; sq_b = {6'd0, r_rd.cy}; end
            tbt_pkg::SQ_VX: begin sq_a = r_in.vx; sq_b = r_rd.vx; end
            default:        begin sq_a = r_in.vy; sq_b = r_rd.vy; end
        endcase
        sq_clear = (r_state == S_CHK) || (r_state == S_SQ2);
        sq_en = (r_state == S_SQ0) || (r_state == S_SQ1)
             || (r_state == S_SQ2) || (r_state == S_SQ3);
    end

    tbt_sqacc u_sq (
        .i_clk(i_clk), .i_clear(sq_clear), .i_en(sq_en),
        .i_a(sq_a), .i_b(sq_b), .o_acc(sq_acc)
    );

    // entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            mem[r_wa] <= r_in;
        end
        r_rd <= mem[idx];
    end

    logic in_win;
    assign in_win = (i_center_x > r_minx) && (i_center_x < r_maxx)
                 && (i_center_y > r_miny) && (i_center_y < r_maxy);

    always_ff @(posedge i_clk) begin
        r_wr <= 1'b0;
        o_valid <= 1'b0;
        o_last_of_run <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld <= '0;
            r_fnd <= '0;
            r_upd <= '0;
            r_minx <= 15'd512;
            r_maxx <= 15'd9728;
            r_miny <= 15'd0;
            r_maxy <= 15'd7680;
            r_pos_s <= 11'd160;
            r_vel_s <= 13'd41;
            r_idx <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    tbt_pkg::REG_MIN_X: r_minx <= i_cfg_data;
                    tbt_pkg::REG_MAX_X: r_maxx <= i_cfg_data;
                    tbt_pkg::REG_MIN_Y: r_miny <= i_cfg_data;
                    tbt_pkg::REG_MAX_Y: r_maxy <= i_cfg_data;
                    tbt_pkg::REG_POS_S: r_pos_s <= i_cfg_data[10:0];
                    tbt_pkg::REG_VEL_S: r_vel_s <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_has_free <= 1'b0;
                    if (start) begin
                        r_in <= '{i_blob_label, i_center_x, i_center_y, i_velocity_x,
                                  i_velocity_y, i_box_x, i_box_y, i_box_width,
                                  i_box_height};
                        if (i_operation) begin
                            r_state <= S_DEL;
                        end else if (in_win) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // memory read of slot idx is issued; check next cycle
                    r_slot <= idx;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_vld[r_slot] && r_rd.label == r_in.label) begin
                        r_fnd[r_slot] <= 1'b1;
                        r_state <= S_SQ0;
                    end else begin
                        if (!r_vld[r_slot] && !r_has_free) begin
                            r_has_free <= 1'b1;
                            r_free <= CW'(r_slot);
                        end
                        if (CW'(r_slot) == CW'(TABLE_ENTRIES - 1)) begin
                            if (r_has_free || !r_vld[r_slot]) begin
                                r_wr <= 1'b1;
                                r_wa <= r_has_free ? r_free[IW-1:0] : r_slot;
                                r_vld[r_has_free ? r_free[IW-1:0] : r_slot] <= 1'b1;
                                r_fnd[r_has_free ? r_free[IW-1:0] : r_slot] <= 1'b1;
                                r_upd[r_has_free ? r_free[IW-1:0] : r_slot] <= 1'b1;
                            end else begin
                                o_valid <= 1'b1;
                                o_last_of_run <= 1'b1;
                                o_report_kind <= tbt_pkg::KIND_DROP;
                                o_report_label <= r_in.label;
                                o_report_center_x <= r_in.cx;
                                o_report_center_y <= r_in.cy;
                                o_report_velocity_x <= r_in.vx;
                                o_report_velocity_y <= r_in.vy;
                                o_report_box_x <= r_in.bx;
                                o_report_box_y <= r_in.by;
                                o_report_box_width <= r_in.bw;
                                o_report_box_height <= r_in.bh;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SQ0: r_state <= S_SQ1;
                S_SQ1: r_state <= S_SQ2;
                S_SQ2: begin
                    r_dp <= sq_acc;
                    r_state <= S_SQ3;
                end
                S_SQ3: r_state <= S_DEC;
                S_DEC: begin
                    if (r_dp > 44'(r_pos_s) * 44'(r_pos_s)
                            || sq_acc > 44'(r_vel_s) * 44'(r_vel_s)) begin
                        r_wr <= 1'b1;
                        r_wa <= r_slot;
                        r_upd[r_slot] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_DEL: begin
                    r_slot <= idx;
                    r_state <= S_DEL_OUT;
                end
                S_DEL_OUT: begin
                    if (r_vld[r_slot] && !r_fnd[r_slot]) begin
                        o_valid <= 1'b1;
                        o_report_kind <= tbt_pkg::KIND_DELETE;
                        o_report_label <= r_rd.label;
                        o_report_center_x <= '0;
                        o_report_center_y <= '0;
                        o_report_velocity_x <= '0;
                        o_report_velocity_y <= '0;
                        o_report_box_x <= '0;
                        o_report_box_y <= '0;
                        o_report_box_width <= '0;
                        o_report_box_height <= '0;
                        r_vld[r_slot] <= 1'b0;
                        r_upd[r_slot] <= 1'b0;
                    end
                    if (CW'(r_slot) == CW'(TABLE_ENTRIES - 1)) begin
                        r_idx <= '0;
                        r_state <= S_UPD;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_state <= S_DEL;
                    end
                end
                S_UPD: begin
                    r_slot <= idx;
                    r_state <= S_UPD_OUT;
                end
                S_UPD_OUT: begin
                    if (r_vld[r_slot] && r_upd[r_slot]) begin
                        o_valid <= 1'b1;
                        o_report_kind <= tbt_pkg::KIND_UPDATE;
                        o_report_label <= r_rd.label;
                        o_report_center_x <= r_rd.cx;
                        o_report_center_y <= r_rd.cy;
                        o_report_velocity_x <= r_rd.vx;
                        o_report_velocity_y <= r_rd.vy;
                        o_report_box_x <= r_rd.bx;
                        o_report_box_y <= r_rd.by;
                        o_report_box_width <= r_rd.bw;
                        o_report_box_height <= r_rd.bh;
                    end
                    r_upd[r_slot] <= 1'b0;
                    r_fnd[r_slot] <= 1'b0;
                    if (CW'(r_slot) == CW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_FRAME;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_state <= S_UPD;
                    end
                end
                S_FRAME: begin
                    o_valid <= 1'b1;
                    o_last_of_run <= 1'b1;
                    o_report_kind <= tbt_pkg::KIND_FRAME;
                    o_report_label <= '0;
                    o_report_center_x <= '0;
                    o_report_center_y <= '0;
                    o_report_velocity_x <= '0;
                    o_report_velocity_y <= '0;
                    o_report_box_x <= '0;
                    o_report_box_y <= '0;
                    o_report_box_width <= '0;
                    o_report_box_height <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_drop_last;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_report_kind == tbt_pkg::KIND_DROP) |-> o_last_of_run;
    endproperty
    a_drop_last: assert property (p_drop_last) else $error("drop without last");

    property p_idle_no_write;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !(o_valid && o_report_kind == tbt_pkg::KIND_DELETE);
    endproperty
    a_idle_no_write: assert property (p_idle_no_write) else $error("delete from idle");

    property p_upd_valid;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |=> (r_upd & ~r_vld) == '0;
    endproperty
    a_upd_valid: assert property (p_upd_valid) else $error("update flag on free slot");
endmodule
`default_nettype wire

// ===== tb/sv/tb_tracked_blob_table_unit.sv =====
// testbench for tracked_blob_table_unit: frames of detections with random
// content checked against a scoreboard that tracks the table on its own
// depends on tbt_pkg and the tracked_blob_table_unit rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_tracked_blob_table_unit;
    localparam int SLOTS = 32;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int POOL = 40;
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef struct {
        logic op;
        logic [31:0] label;
        logic [14:0] cx, cy;
        logic [20:0] vx, vy;
        logic [10:0] bx, by, bw, bh;
    } t_request;

    typedef struct {
        tbt_pkg::t_kind kind;
        logic [31:0] label;
        logic [14:0] cx, cy;
        logic [20:0] vx, vy;
        logic [10:0] bx, by, bw, bh;
        logic last;
    } t_report;

    class blob_table_scoreboard;
        tbt_pkg::t_entry slot[SLOTS];
        bit valid[SLOTS], found[SLOTS], flagged[SLOTS];
        logic [14:0] min_x, max_x, min_y, max_y;
        logic [10:0] pos_sens;
        logic [12:0] vel_sens;
        t_report pending[$];
        int errors, reports, drops, deletes;

        function new();
            min_x = 512; max_x = 9728; min_y = 0; max_y = 7680;
            pos_sens = 160; vel_sens = 41;
            foreach (valid[i]) begin
                valid[i] = 0; found[i] = 0; flagged[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [14:0] d);
            case (idx)
                tbt_pkg::REG_MIN_X: min_x = d;
                tbt_pkg::REG_MAX_X: max_x = d;
                tbt_pkg::REG_MIN_Y: min_y = d;
                tbt_pkg::REG_MAX_Y: max_y = d;
                tbt_pkg::REG_POS_S: pos_sens = d[10:0];
                tbt_pkg::REG_VEL_S: vel_sens = d[12:0];
                default: ;
            endcase
        endfunction

        function void push(tbt_pkg::t_kind k, tbt_pkg::t_entry e, logic last);
            t_report r;
            r.kind = k; r.label = e.label; r.cx = e.cx; r.cy = e.cy;
            r.vx = e.vx; r.vy = e.vy; r.bx = e.bx; r.by = e.by;
            r.bw = e.bw; r.bh = e.bh; r.last = last;
            pending.push_back(r);
        endfunction

        function longint sq(longint d);
            return d * d;
        endfunction

        function void note_request(t_request q);
            tbt_pkg::t_entry e, z;
            int free_slot;
            longint dp, dv;
            z = '0;
            if (q.op == OP_FRAME) begin
                for (int i = 0; i < SLOTS; i++)
                    if (valid[i] && !found[i]) begin
                        z.label = slot[i].label;
                        push(tbt_pkg::KIND_DELETE, z, 1'b0);
                        valid[i] = 0; flagged[i] = 0; deletes++;
                    end
                for (int i = 0; i < SLOTS; i++) begin
                    if (valid[i] && flagged[i]) push(tbt_pkg::KIND_UPDATE, slot[i], 1'b0);
                    flagged[i] = 0; found[i] = 0;
                end
                z.label = '0;
                push(tbt_pkg::KIND_FRAME, z, 1'b1);
                return;
            end
            e.label = q.label; e.cx = q.cx; e.cy = q.cy; e.vx = q.vx; e.vy = q.vy;
            e.bx = q.bx; e.by = q.by; e.bw = q.bw; e.bh = q.bh;
            if (!(q.cx > min_x && q.cx < max_x && q.cy > min_y && q.cy < max_y))
                return;
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (slot[i].label == q.label) begin
                    dp = sq(longint'(q.cx) - longint'(slot[i].cx))
                       + sq(longint'(q.cy) - longint'(slot[i].cy));
                    dv = sq(longint'($signed(q.vx)) - longint'($signed(slot[i].vx)))
                       + sq(longint'($signed(q.vy)) - longint'($signed(slot[i].vy)));
                    found[i] = 1;
                    if (dp > sq(longint'(pos_sens)) || dv > sq(longint'(vel_sens))) begin
                        slot[i] = e; flagged[i] = 1;
                    end
                    return;
                end
            end
            if (free_slot < 0) begin
                push(tbt_pkg::KIND_DROP, e, 1'b1);
                drops++;
                return;
            end
            valid[free_slot] = 1; found[free_slot] = 1; flagged[free_slot] = 1;
            slot[free_slot] = e;
        endfunction

        function bit same(string name, logic [31:0] x, logic [31:0] a);
            if (x !== a) begin
                $display("%0t: %s expected %h actual %h", $time, name, x, a);
                return 0;
            end
            return 1;
        endfunction

        function void check_result(t_report a);
            t_report x;
            bit ok;
            reports++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected report kind %0d label %h", $time, a.kind, a.label);
                errors++;
                return;
            end
            x = pending.pop_front();
            ok = same("kind", x.kind, a.kind);
            ok &= same("label", x.label, a.label);
            ok &= same("center_x", x.cx, a.cx);
            ok &= same("center_y", x.cy, a.cy);
            ok &= same("velocity_x", x.vx, a.vx);
            ok &= same("velocity_y", x.vy, a.vy);
            ok &= same("box_x", x.bx, a.bx);
            ok &= same("box_y", x.by, a.by);
            ok &= same("box_width", x.bw, a.bw);
            ok &= same("box_height", x.bh, a.bh);
            ok &= same("last_of_run", x.last, a.last);
            if (!ok) errors++;
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic busy, o_cfg_ready, o_valid, o_last_of_run;
    logic i_cfg_valid = 0;
    logic [2:0] i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;
    logic i_operation = 0;
    logic [31:0] i_blob_label = '0;
    logic [14:0] i_center_x = '0, i_center_y = '0;
    logic signed [20:0] i_velocity_x = '0, i_velocity_y = '0;
    logic [10:0] i_box_x = '0, i_box_y = '0, i_box_width = '0, i_box_height = '0;
    logic [1:0] o_report_kind;
    logic [31:0] o_report_label;
    logic [14:0] o_report_center_x, o_report_center_y;
    logic signed [20:0] o_report_velocity_x, o_report_velocity_y;
    logic [10:0] o_report_box_x, o_report_box_y, o_report_box_width, o_report_box_height;

    tracked_blob_table_unit #(.TABLE_ENTRIES(SLOTS)) u_top (.*);

    always #2 i_clk = ~i_clk;

    blob_table_scoreboard sb = new();
    int idle_cycles = 0;
    int requests = 0;
    int burst_left = 0;
    logic [31:0] labels[POOL];
    int base_cx[POOL], base_cy[POOL], base_vx[POOL], base_vy[POOL];

    // outputs and handshakes are sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        t_request q;
        t_report a;
        bit moved;
        moved = 0;
        if (i_rst_n) begin
            if (start && !busy) begin
                q.op = i_operation; q.label = i_blob_label;
                q.cx = i_center_x; q.cy = i_center_y;
                q.vx = i_velocity_x; q.vy = i_velocity_y;
                q.bx = i_box_x; q.by = i_box_y; q.bw = i_box_width; q.bh = i_box_height;
                sb.note_request(q);
                requests++;
                moved = 1;
            end
            if (o_valid) begin
                a.kind = tbt_pkg::t_kind'(o_report_kind); a.label = o_report_label;
                a.cx = o_report_center_x; a.cy = o_report_center_y;
                a.vx = o_report_velocity_x; a.vy = o_report_velocity_y;
                a.bx = o_report_box_x; a.by = o_report_box_y;
                a.bw = o_report_box_width; a.bh = o_report_box_height;
                a.last = o_last_of_run;
                sb.check_result(a);
                moved = 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                moved = 1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("timeout with %0d reports outstanding", sb.pending.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_request mk(logic op, logic [31:0] label, int cx, int cy,
                                    int vx, int vy, int bx, int by, int bw, int bh);
        t_request q;
        q.op = op; q.label = label; q.cx = 15'(cx); q.cy = 15'(cy);
        q.vx = 21'(vx); q.vy = 21'(vy);
        q.bx = 11'(bx); q.by = 11'(by); q.bw = 11'(bw); q.bh = 11'(bh);
        return q;
    endfunction

    task automatic send(t_request q, bit bursty);
        bit ok;
        start <= 1'b1;
        i_operation <= q.op; i_blob_label <= q.label;
        i_center_x <= q.cx; i_center_y <= q.cy;
        i_velocity_x <= q.vx; i_velocity_y <= q.vy;
        i_box_x <= q.bx; i_box_y <= q.by; i_box_width <= q.bw; i_box_height <= q.bh;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        if (bursty) begin
            if (burst_left == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
            end else
                burst_left--;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [14:0] d);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int wander(int v, int lo, int hi, bit big);
        int d;
        d = big ? $urandom_range(150, 2000) : $urandom_range(0, 120);
        v = $urandom_range(0, 1) ? v + d : v - d;
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_request random_detection(int k);
        t_request q;
        bit big;
        if ($urandom_range(0, 9) == 0)
            return mk(OP_DETECT, $urandom_range(0, 3) == 0 ? $urandom : labels[k],
                      $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        big = $urandom_range(0, 2) == 0;
        base_cx[k] = wander(base_cx[k], 1, 32766, big);
        base_cy[k] = wander(base_cy[k], 1, 32766, big);
        big = $urandom_range(0, 2) == 0;
        base_vx[k] = wander(base_vx[k], -1048576, 1048575, big) / (big ? 1 : 1);
        base_vy[k] = wander(base_vy[k], -1048576, 1048575, big);
        return mk(OP_DETECT, labels[k], base_cx[k], base_cy[k], base_vx[k], base_vy[k],
                  $urandom, $urandom, $urandom, $urandom);
    endfunction

    initial begin
        t_request fr;
        int frame_len, first;
        fr = mk(OP_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        foreach (labels[k]) begin
            labels[k] = $urandom;
            base_cx[k] = $urandom_range(600, 9600);
            base_cy[k] = $urandom_range(100, 7600);
            base_vx[k] = $urandom_range(0, 8000) - 4000;
            base_vy[k] = $urandom_range(0, 8000) - 4000;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window edges, field extremes, refresh thresholds, deletes
        send(mk(OP_DETECT, 32'h0, 513, 1, -1048576, 1048575, 0, 0, 0, 0), 0);
        send(mk(OP_DETECT, 32'hFFFF_FFFF, 9727, 7679, 1048575, -1048576,
                2047, 2047, 2047, 2047), 0);
        send(mk(OP_DETECT, 5, 512, 100, 0, 0, 1, 2, 3, 4), 0);
        send(mk(OP_DETECT, 6, 9728, 100, 0, 0, 1, 2, 3, 4), 0);
        send(mk(OP_DETECT, 7, 1000, 0, 0, 0, 1, 2, 3, 4), 0);
        send(mk(OP_DETECT, 8, 1000, 7680, 0, 0, 1, 2, 3, 4), 0);
        send(mk(OP_DETECT, 9, 32767, 32767, 0, 0, 1, 2, 3, 4), 0);
        send(mk(OP_DETECT, 32'h0, 513, 1, -1048576, 1048575, 5, 5, 5, 5), 0);
        send(fr, 0);
        send(mk(OP_DETECT, 32'h0, 674, 1, -1048576, 1048575, 6, 6, 6, 6), 0);
        send(mk(OP_DETECT, 32'hFFFF_FFFF, 9567, 7679, 1048575, -1048576, 7, 7, 7, 7), 0);
        send(mk(OP_DETECT, 32'hFFFF_FFFF, 9567, 7679, 1048534, -1048576, 8, 8, 8, 8), 0);
        send(mk(OP_DETECT, 32'h0, 674, 1, -1048576, 1048533, 9, 9, 9, 9), 0);
        send(fr, 0);
        send(fr, 0);
        send(fr, 0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(tbt_pkg::REG_MIN_X, 512); write_reg(tbt_pkg::REG_MAX_X, 9728);
                    write_reg(tbt_pkg::REG_MIN_Y, 0); write_reg(tbt_pkg::REG_MAX_Y, 7680);
                    write_reg(tbt_pkg::REG_POS_S, 160); write_reg(tbt_pkg::REG_VEL_S, 41);
                end
                1: begin
                    write_reg(tbt_pkg::REG_MIN_X, 0); write_reg(tbt_pkg::REG_MAX_X, 32767);
                    write_reg(tbt_pkg::REG_MIN_Y, 0); write_reg(tbt_pkg::REG_MAX_Y, 32767);
                    write_reg(tbt_pkg::REG_POS_S, 16); write_reg(tbt_pkg::REG_VEL_S, 0);
                end
                2: begin
                    write_reg(tbt_pkg::REG_POS_S, 15'h7FFF);
                    write_reg(tbt_pkg::REG_VEL_S, 15'h7FFF);
                    write_reg(tbt_pkg::REG_MIN_Y, 32767);
                    write_reg(tbt_pkg::REG_MIN_Y, 50);
                end
                default: begin
                    write_reg(REG_UNUSED, 15'h7FFF);
                    write_reg(tbt_pkg::REG_MIN_X, 300); write_reg(tbt_pkg::REG_MAX_X, 20000);
                    write_reg(tbt_pkg::REG_MIN_Y, 200); write_reg(tbt_pkg::REG_MAX_Y, 16000);
                    write_reg(tbt_pkg::REG_POS_S, 1280); write_reg(tbt_pkg::REG_VEL_S, 4096);
                end
            endcase
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
            while (requests < 16 + (phase + 1) * 108) begin
                if ($urandom_range(0, 7) == 0) begin
                    frame_len = $urandom_range(34, 38);
                    first = $urandom_range(0, POOL - 1);
                    for (int n = 0; n < frame_len; n++)
                        send(random_detection((first + n) % POOL), 1);
                end else begin
                    frame_len = $urandom_range(0, 10);
                    for (int n = 0; n < frame_len; n++)
                        send(random_detection($urandom_range(0, POOL - 1)), 1);
                end
                send(fr, 1);
            end
            drain();
        end

        $display("%0d requests, %0d reports checked (%0d drops, %0d deletes), 4 register setups",
                 requests, sb.reports, sb.drops, sb.deletes);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
